// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define PMSD_ASSERT_ALWAYS(name, ck, rn, prop) \
    name: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("assertion failed: always");

// Same-cycle implication.
`define PMSD_ASSERT_IMP(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("assertion failed: implication");

// Next-cycle implication.
`define PMSD_ASSERT_NEXT(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/pmsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pmsd_pkg
// Shared constants and controller/datapath interface types for the decimator.
// ---------------------------------------------------------------------------
package pmsd_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF  = 24;
    localparam int LENGTH_BITS_DEF = 32;

    // Spacing register
    localparam int                  SPACING_BITS    = 24;
    localparam logic [SPACING_BITS-1:0] MIN_SPACING_RST = 24'd1000;

    // Kept-point counter codes
    localparam logic [1:0] KEPT_NONE = 2'd0;
    localparam logic [1:0] KEPT_ONE  = 2'd1;
    localparam logic [1:0] KEPT_MAX  = 2'd2;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;     // latch input item
        logic sq_x;        // square |dx|
        logic sq_y;        // square |dy|
        logic root_start;  // launch square root
        logic accum;       // add segment length
        logic emit_first;  // output first point of a lane
        logic emit_mid;    // output midpoint
        logic emit_point;  // output kept point
    } pmsd_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic lane_started; // a lane is in progress
        logic sqrt_done;    // root ready
        logic keep;         // current point is kept
        logic need_mid;     // midpoint goes out first
        logic out_free;     // output register can load
    } pmsd_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pmsd_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pmsd_isqrt
// Digit-by-digit floor square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module pmsd_isqrt
    import pmsd_pkg::*;
#(
    parameter int RW = COORD_BITS_DEF + 1
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2*RW-1:0] radicand,
    output logic                 done,
    output logic [RW-1:0]        root
);

    localparam int CNT_W = $clog2(RW + 1);

    logic [2*RW-1:0] rad_reg,  rad_next;
    logic [RW-1:0]   rem_reg,  rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;

    // One trial subtraction per cycle
    always_comb begin
        rem_sh = {rem_reg, rad_reg[2*RW-1 -: 2]};
        trial  = {root_reg, 2'b01};
        ge     = (rem_sh >= trial);
        diff   = rem_sh - trial;

        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(RW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[2*RW-3:0], 2'b00};
            rem_next  = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
            root_next = {root_reg[RW-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/pmsd_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pmsd_dp
// Datapath: segment length, arc length accumulation, keep test, output item.
// ---------------------------------------------------------------------------
module pmsd_dp
    import pmsd_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [SPACING_BITS-1:0]       cfg_wdata,
    input  wire logic signed [COORD_BITS-1:0]  point_x,
    input  wire logic signed [COORD_BITS-1:0]  point_y,
    input  wire logic                          is_last,
    input  wire logic                          out_ready,
    input  wire pmsd_cmd_t                     cmd,
    output pmsd_status_t                       status,
    output logic                               out_valid,
    output logic signed [COORD_BITS-1:0]       kept_x,
    output logic signed [COORD_BITS-1:0]       kept_y,
    output logic [LENGTH_BITS-1:0]             arc_length,
    output logic                               lane_end
);

    localparam int C  = COORD_BITS;
    localparam int L  = LENGTH_BITS;
    localparam int D  = C + 1;                  // difference / magnitude width
    localparam int R  = C + 1;                  // root width
    localparam int SW = ((L > R) ? L : R) + 1;  // sum width before saturation
    localparam int CW = (L > SPACING_BITS) ? L : SPACING_BITS;

    // State
    logic [SPACING_BITS-1:0] min_spacing_reg;
    logic [C-1:0] x_reg, y_reg, prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;
    logic         last_reg;
    logic [L-1:0] total_reg, since_reg;
    logic [1:0]   kept_count_reg;
    logic         lane_started_reg;
    logic [2*D-1:0] sqx_reg, sqy_reg;

    // Output register
    logic         out_valid_reg, out_valid_next;
    logic [C-1:0] kept_x_reg, kept_y_reg;
    logic [L-1:0] arc_reg;
    logic         end_reg;

    logic [D-1:0]   dx, dy, mag_dx, mag_dy, mag_sel;
    logic [2*D-1:0] sq;
    logic [2*R-1:0] rad_sum;
    logic [R-1:0]   root;
    logic           sqrt_done;
    logic [SW-1:0]  tot_sum, since_sum;
    logic [L-1:0]   tot_sat, since_sat;
    logic [D-1:0]   mid_x_sum, mid_y_sum;
    logic           out_free;

    // Segment deltas and shared squarer
    always_comb begin
        dx      = {x_reg[C-1], x_reg} - {prev_x_reg[C-1], prev_x_reg};
        dy      = {y_reg[C-1], y_reg} - {prev_y_reg[C-1], prev_y_reg};
        mag_dx  = dx[D-1] ? (D'(0) - dx) : dx;
        mag_dy  = dy[D-1] ? (D'(0) - dy) : dy;
        mag_sel = cmd.sq_y ? mag_dy : mag_dx;
        sq      = mag_sel * mag_sel;
        rad_sum = sqx_reg + sqy_reg;
    end

    pmsd_isqrt #(
        .RW (R)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (rad_sum),
        .done     (sqrt_done),
        .root     (root)
    );

    // Saturating accumulation
    always_comb begin
        tot_sum   = SW'(total_reg) + SW'(root);
        since_sum = SW'(since_reg) + SW'(root);
        tot_sat   = (|tot_sum[SW-1:L])   ? {L{1'b1}} : tot_sum[L-1:0];
        since_sat = (|since_sum[SW-1:L]) ? {L{1'b1}} : since_sum[L-1:0];
    end

    // Midpoint, floor of the halved sum
    always_comb begin
        mid_x_sum = {first_x_reg[C-1], first_x_reg} + {x_reg[C-1], x_reg};
        mid_y_sum = {first_y_reg[C-1], first_y_reg} + {y_reg[C-1], y_reg};
    end

    // Status to controller
    always_comb begin
        out_free            = !out_valid_reg || out_ready;
        status.lane_started = lane_started_reg;
        status.sqrt_done    = sqrt_done;
        status.keep         = (CW'(since_reg) > CW'(min_spacing_reg)) || last_reg;
        status.need_mid     = last_reg && (kept_count_reg == KEPT_ONE);
        status.out_free     = out_free;
    end

    // Output valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_first || cmd.emit_mid || cmd.emit_point) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control and lane state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_spacing_reg  <= MIN_SPACING_RST;
            out_valid_reg    <= 1'b0;
            lane_started_reg <= 1'b0;
            kept_count_reg   <= KEPT_NONE;
            total_reg        <= '0;
            since_reg        <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                min_spacing_reg <= cfg_wdata;
            end
            if (cmd.emit_first) begin
                lane_started_reg <= !last_reg;
                kept_count_reg   <= KEPT_ONE;
                total_reg        <= '0;
                since_reg        <= '0;
            end
            if (cmd.accum) begin
                total_reg <= tot_sat;
                since_reg <= since_sat;
            end
            if (cmd.emit_point) begin
                since_reg <= '0;
                if (kept_count_reg != KEPT_MAX) begin
                    kept_count_reg <= kept_count_reg + 2'd1;
                end
                if (last_reg) begin
                    lane_started_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            x_reg    <= point_x;
            y_reg    <= point_y;
            last_reg <= is_last;
        end
        if (cmd.sq_x) begin
            sqx_reg <= sq;
        end
        if (cmd.sq_y) begin
            sqy_reg <= sq;
        end
        if (cmd.emit_first) begin
            first_x_reg <= x_reg;
            first_y_reg <= y_reg;
            prev_x_reg  <= x_reg;
            prev_y_reg  <= y_reg;
            kept_x_reg  <= x_reg;
            kept_y_reg  <= y_reg;
            arc_reg     <= '0;
            end_reg     <= last_reg;
        end
        if (cmd.accum) begin
            prev_x_reg <= x_reg;
            prev_y_reg <= y_reg;
        end
        if (cmd.emit_mid) begin
            kept_x_reg <= mid_x_sum[C:1];
            kept_y_reg <= mid_y_sum[C:1];
            arc_reg    <= {1'b0, total_reg[L-1:1]};
            end_reg    <= 1'b0;
        end
        if (cmd.emit_point) begin
            kept_x_reg <= x_reg;
            kept_y_reg <= y_reg;
            arc_reg    <= total_reg;
            end_reg    <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kept_x     = kept_x_reg;
    assign kept_y     = kept_y_reg;
    assign arc_length = arc_reg;
    assign lane_end   = end_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/pmsd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pmsd_ctrl
// Sequencer: steps one item through square, root, accumulate and emit.
// ---------------------------------------------------------------------------
module pmsd_ctrl
    import pmsd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire pmsd_status_t status,
    output pmsd_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIRST  = 4'd1;
    localparam logic [3:0] S_SQX    = 4'd2;
    localparam logic [3:0] S_SQY    = 4'd3;
    localparam logic [3:0] S_LOAD   = 4'd4;
    localparam logic [3:0] S_ROOT   = 4'd5;
    localparam logic [3:0] S_ACCUM  = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_MID    = 4'd8;
    localparam logic [3:0] S_POINT  = 4'd9;

    logic [3:0] state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = status.lane_started ? S_SQX : S_FIRST;
                end
            end
            S_FIRST: begin
                if (status.out_free) begin
                    cmd.emit_first = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = S_SQY;
            end
            S_SQY: begin
                cmd.sq_y   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.root_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT: begin
                if (status.sqrt_done) begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (!status.keep) begin
                    state_next = S_IDLE;
                end else if (status.need_mid) begin
                    state_next = S_MID;
                end else begin
                    state_next = S_POINT;
                end
            end
            S_MID: begin
                if (status.out_free) begin
                    cmd.emit_mid = 1'b1;
                    state_next   = S_POINT;
                end
            end
            S_POINT: begin
                if (status.out_free) begin
                    cmd.emit_point = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/polyline_min_spacing_decimator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// polyline_min_spacing_decimator
// Thins a lane point stream to points spaced by a minimum arc length.
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    point_x, point_y, is_last
//  out      out_valid / out_ready  kept_x, kept_y, arc_length, lane_end
//  cfg      cfg_we                 cfg_wdata (min_spacing)
//
//  First point of a lane: S_FIRST lies between its accept and the next accept.
//  Later points step through S_SQX, S_SQY, S_LOAD, S_ROOT, S_ACCUM and
//  S_DECIDE, with the root built one bit per cycle (COORD_BITS + 1 root bits);
//  a kept point adds S_POINT, and a midpoint adds S_MID before it.
//  One item is in flight at a time; a result waiting in the output register
//  does not block the next accept, only the next load of that register.
//  Reset clears the lane state and sets min_spacing to 1000; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module polyline_min_spacing_decimator
    import pmsd_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [SPACING_BITS-1:0]       cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_BITS-1:0]  point_x,
    input  wire logic signed [COORD_BITS-1:0]  point_y,
    input  wire logic                          is_last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_BITS-1:0]       kept_x,
    output logic signed [COORD_BITS-1:0]       kept_y,
    output logic [LENGTH_BITS-1:0]             arc_length,
    output logic                               lane_end
);

    pmsd_cmd_t    cmd;
    pmsd_status_t st;

    pmsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (st),
        .cmd      (cmd)
    );

    pmsd_dp #(
        .COORD_BITS  (COORD_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .point_x    (point_x),
        .point_y    (point_y),
        .is_last    (is_last),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (st),
        .out_valid  (out_valid),
        .kept_x     (kept_x),
        .kept_y     (kept_y),
        .arc_length (arc_length),
        .lane_end   (lane_end)
    );

    // Emit commands, gathered for checks
    logic [2:0] emit_vec;
    logic       emit_any;
    assign emit_vec = {cmd.emit_first, cmd.emit_mid, cmd.emit_point};
    assign emit_any = |emit_vec;

    // Checks
    `PMSD_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
    `PMSD_ASSERT_IMP(a_load_when_free, clk, rst_n, emit_any, st.out_free)
    `PMSD_ASSERT_ALWAYS(a_single_emit, clk, rst_n, $onehot0(emit_vec))
    `PMSD_ASSERT_IMP(a_root_busy, clk, rst_n, st.sqrt_done, !in_ready)

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for polyline_min_spacing_decimator. A lane predictor
// runs next to the block, queues the kept points and midpoints that each
// accepted point must produce, and checks every result against them. The
// stimulus covers directed corner lanes, random walks scaled to the spacing,
// noise, an arc length saturation lane and a long output stall.
// ---------------------------------------------------------------------------
module testbench
    import pmsd_pkg::*;
;

    localparam int CW              = COORD_BITS_DEF;
    localparam int LW              = LENGTH_BITS_DEF;
    localparam int SETTLE_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int ITEM_BUDGET     = 1050;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [LW-1:0]        length_t;

    localparam coord_t  COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t  COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam length_t LEN_MAX   = '1;
    localparam logic [SPACING_BITS-1:0] SPACING_MAX = '1;

    typedef struct packed {
        coord_t  x;
        coord_t  y;
        length_t arc;
        logic    lane_end;
    } kept_point_t;

    // Lane predictor and store of expected kept points
    class lane_scoreboard;
        logic [SPACING_BITS-1:0] spacing;
        coord_t      prev_x, prev_y, first_x, first_y;
        length_t     arc_total, since_kept;
        logic [1:0]  kept_count;
        bit          in_lane;
        kept_point_t expected_q[$];
        int          errors, checked, points, lanes, midpoints, saturated;

        function new();
            spacing    = MIN_SPACING_RST;
            prev_x     = '0;
            prev_y     = '0;
            first_x    = '0;
            first_y    = '0;
            arc_total  = '0;
            since_kept = '0;
            kept_count = KEPT_NONE;
            in_lane    = 1'b0;
            errors     = 0;
            checked    = 0;
            points     = 0;
            lanes      = 0;
            midpoints  = 0;
            saturated  = 0;
        endfunction

        function void set_spacing(logic [SPACING_BITS-1:0] v);
            spacing = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // bit-serial floor square root; the root stays below 2^(CW+1)
        function longint unsigned floor_root(longint unsigned n);
            longint unsigned r, c;
            r = 0;
            for (int b = CW + 1; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= n)
                    r = c;
            end
            return r;
        endfunction

        function length_t add_sat(length_t a, longint unsigned b);
            longint unsigned s;
            s = 64'(a) + b;
            if (s > 64'(LEN_MAX)) begin
                saturated++;
                return LEN_MAX;
            end
            return length_t'(s);
        endfunction

        // floor of (a + b) / 2, toward minus infinity
        function coord_t half_sum(coord_t a, coord_t b);
            logic signed [CW:0] s;
            s = {a[CW-1], a} + {b[CW-1], b};
            return s[CW:1];
        endfunction

        function void push(coord_t x, coord_t y, length_t arc, logic lane_end);
            kept_point_t p;
            p.x        = x;
            p.y        = y;
            p.arc      = arc;
            p.lane_end = lane_end;
            expected_q = {expected_q, p};
        endfunction

        function void note_point(coord_t x, coord_t y, logic last);
            longint dx, dy;
            longint unsigned seg;
            points++;
            // first point of a lane: always kept at arc length zero
            if (!in_lane) begin
                first_x    = x;
                first_y    = y;
                prev_x     = x;
                prev_y     = y;
                arc_total  = '0;
                since_kept = '0;
                kept_count = KEPT_ONE;
                push(x, y, '0, last);
                in_lane = !last;
                if (last)
                    lanes++;
                return;
            end
            dx  = longint'(x) - longint'(prev_x);
            dy  = longint'(y) - longint'(prev_y);
            seg = floor_root(64'(dx * dx + dy * dy));
            arc_total  = add_sat(arc_total, seg);
            since_kept = add_sat(since_kept, seg);
            prev_x = x;
            prev_y = y;
            if (64'(since_kept) > 64'(spacing) || last) begin
                since_kept = '0;
                // only first and last kept: midpoint goes out first
                if (last && kept_count == KEPT_ONE) begin
                    push(half_sum(first_x, x), half_sum(first_y, y), arc_total >> 1, 1'b0);
                    midpoints++;
                end
                push(x, y, arc_total, last);
                if (kept_count != KEPT_MAX)
                    kept_count++;
            end
            if (last) begin
                in_lane = 1'b0;
                lanes++;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        task check_result(coord_t x, coord_t y, length_t arc, logic lane_end);
            kept_point_t want;
            checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result x=%0d y=%0d arc=%0d lane_end=%0b",
                                 x, y, arc, lane_end));
                return;
            end
            want = expected_q.pop_front();
            if (x !== want.x)
                report($sformatf("result %0d kept_x %0d, expected %0d", checked, x, want.x));
            if (y !== want.y)
                report($sformatf("result %0d kept_y %0d, expected %0d", checked, y, want.y));
            if (arc !== want.arc)
                report($sformatf("result %0d arc_length %0d, expected %0d",
                                 checked, arc, want.arc));
            if (lane_end !== want.lane_end)
                report($sformatf("result %0d lane_end %0b, expected %0b",
                                 checked, lane_end, want.lane_end));
        endtask
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [SPACING_BITS-1:0] cfg_wdata = '0;
    logic                    in_valid  = 1'b0;
    coord_t                  point_x   = '0;
    coord_t                  point_y   = '0;
    logic                    is_last   = 1'b0;
    logic                    out_ready = 1'b0;
    logic                    in_ready;
    logic                    out_valid;
    coord_t                  kept_x;
    coord_t                  kept_y;
    length_t                 arc_length;
    logic                    lane_end;

    lane_scoreboard sb;
    int  sent          = 0;
    int  settings      = 0;
    int  idle_cycles   = 0;
    bit  tx_idle       = 1'b0;
    bit  rx_idle       = 1'b0;
    bit  pressure_req  = 1'b0;

    polyline_min_spacing_decimator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kept_x     (kept_x),
        .kept_y     (kept_y),
        .arc_length (arc_length),
        .lane_end   (lane_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Monitor: feed accepted points to the predictor, check accepted results
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_point(point_x, point_y, is_last);
            if (out_valid && out_ready)
                sb.check_result(kept_x, kept_y, arc_length, lane_end);
        end
    end

    // Watchdog on cycles where no item moves
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Per-axis step of a random walk; -1 means independent random points
    function automatic int pick_step();
        int r, base;
        r    = $urandom_range(0, 99);
        base = int'(sb.spacing);
        if (base > (1 << 21))
            base = 1 << 21;
        if (r < 30)
            return $urandom_range(0, 16);
        if (r < 75)
            return $urandom_range(base / 2, base * 2 + 2);
        if (r < 90)
            return $urandom_range(0, 1 << 22);
        return -1;
    endfunction

    function automatic int pick_lane_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 1;
        if (r < 85)
            return $urandom_range(2, 8);
        return $urandom_range(9, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int len;
        forever begin
            @(posedge clk);
            if (pressure_req) begin
                out_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                pressure_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 99) < 30) begin
                out_ready <= 1'b0;
                len = pick_stall();
                repeat (len) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_point(coord_t x, coord_t y, logic last);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= x;
        point_y  <= y;
        is_last  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_lane(int len, int step);
        coord_t x, y;
        x = coord_t'($urandom());
        y = coord_t'($urandom());
        for (int i = 0; i < len; i++) begin
            send_point(x, y, i == len - 1);
            if (step < 0) begin
                x = coord_t'($urandom());
                y = coord_t'($urandom());
            end
            else begin
                x = x + coord_t'($urandom_range(0, 2 * step) - step);
                y = y + coord_t'($urandom_range(0, 2 * step) - step);
            end
        end
    endtask

    // Mostly well-formed lanes, some raw noise with random lane ends
    task automatic run_random(int budget);
        int n;
        while (budget > 0) begin
            if ($urandom_range(0, 99) < 82) begin
                n = pick_lane_len();
                send_lane(n, pick_step());
            end
            else begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_point(coord_t'($urandom()), coord_t'($urandom()),
                               1'($urandom_range(0, 1)));
            end
            budget -= n;
        end
    endtask

    // Drain: all expected results out, then let a silent item finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_spacing(logic [SPACING_BITS-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_spacing(v);
        settings++;
    endtask

    initial
    begin
        logic [SPACING_BITS-1:0] spacing_pick;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lanes at the reset spacing, no idling
        send_point('0, '0, 1'b1);
        send_point(COORD_MAX, COORD_MIN, 1'b1);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
        send_point(coord_t'(3), coord_t'(-5), 1'b0);
        send_point(coord_t'(4), coord_t'(-2), 1'b1);
        send_point(coord_t'(100), coord_t'(100), 1'b0);
        send_point(coord_t'(100), coord_t'(100), 1'b0);
        send_point(coord_t'(100), coord_t'(100), 1'b1);
        // spacing boundary: equal is not enough, one more is
        send_point('0, '0, 1'b0);
        send_point(coord_t'(1000), '0, 1'b0);
        send_point(coord_t'(1001), '0, 1'b0);
        send_point(coord_t'(2002), '0, 1'b0);
        send_point(coord_t'(2500), '0, 1'b0);
        send_point(coord_t'(3000), '0, 1'b1);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b1);
        send_point('0, '0, 1'b0);
        send_point(coord_t'(3), coord_t'(4), 1'b0);
        send_point(coord_t'(5), coord_t'(5), 1'b1);
        wait_idle();

        // Zero spacing with idling on both sides
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_spacing('0);
        run_random(150);
        wait_idle();

        // Largest spacing, then a long corner-to-corner lane to saturate
        write_spacing(SPACING_MAX);
        run_random(120);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int i = 0; i < 200; i++) begin
            if (i[0])
                send_point(COORD_MAX, COORD_MAX, i == 199);
            else
                send_point(COORD_MIN, COORD_MIN, i == 199);
        end
        wait_idle();

        // Long output hold-off while points keep coming
        write_spacing('0);
        pressure_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_point(coord_t'(i * 37), coord_t'(-i * 11), i == 29);
        wait_idle();

        // Random phases over assorted spacings
        while (sent < ITEM_BUDGET) begin
            case ($urandom_range(0, 3))
                0: spacing_pick = MIN_SPACING_RST;
                1: spacing_pick = SPACING_BITS'($urandom_range(1, 5000));
                2: spacing_pick = SPACING_BITS'($urandom_range(5000, 200000));
                default: spacing_pick = SPACING_BITS'($urandom());
            endcase
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            write_spacing(spacing_pick);
            run_random(100);
            wait_idle();
        end

        $display("Covered %0d points in %0d lanes over %0d spacing writes;",
                 sb.points, sb.lanes, settings);
        $display("%0d results checked, %0d midpoints, %0d saturating additions.",
                 sb.checked, sb.midpoints, sb.saturated);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
